### hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps

package kts_pkg;

    localparam int MAX_KEYS       = 256;
    localparam int MAX_COMPONENTS = 8;
    localparam int KEY_W          = $clog2(MAX_KEYS);
    localparam int COMP_W         = $clog2(MAX_COMPONENTS);
    localparam int VAL_DEPTH      = MAX_KEYS * 3 * MAX_COMPONENTS;
    localparam int VAL_AW         = $clog2(VAL_DEPTH);

    // divider operand widths: 32-bit magnitude shifted up by 16, 33-bit divisor
    localparam int DVD_W = 49;
    localparam int DVS_W = 33;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] KIND_TIME   = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [1:0] SLOT_IN  = 2'd0;
    localparam logic [1:0] SLOT_VAL = 2'd1;
    localparam logic [1:0] SLOT_OUT = 2'd2;
    localparam logic [1:0] SLOT_BAD = 2'd3;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_STEP   = 2'd1;
    localparam logic [1:0] MODE_CUBIC  = 2'd2;

    localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
    localparam logic [1:0] REG_COMP_COUNT  = 2'd1;
    localparam logic [1:0] REG_MODE        = 2'd2;
    localparam logic [1:0] REG_LOOP_PERIOD = 2'd3;

    // last step of the per-component sequence for each mode
    localparam logic [3:0] LAST_STEP_CUBIC  = 4'd8;
    localparam logic [3:0] LAST_STEP_LINEAR = 4'd4;
    localparam logic [3:0] LAST_STEP_STEP   = 4'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRAP_GO,
        ST_WRAP_WAIT,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CLAMP,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_RD_NEXT,
        ST_RD_PREV,
        ST_GAP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQ,
        ST_CUBE,
        ST_HERM,
        ST_COMP,
        ST_EMIT
    } kts_state_t;

    function automatic logic [VAL_AW-1:0] val_addr(input logic [KEY_W-1:0] key,
                                                   input logic [1:0] slot,
                                                   input logic [COMP_W-1:0] el);
        logic [VAL_AW-1:0] row;
        row = VAL_AW'(key) * VAL_AW'(3) + VAL_AW'(slot);
        return VAL_AW'(row * VAL_AW'(MAX_COMPONENTS)) + VAL_AW'(el);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // round half up, then saturate
    function automatic logic signed [31:0] rnd_sat16(input logic signed [65:0] x);
        logic signed [65:0] y;
        y = (x + 66'sd32768) >>> 16;
        return sat32(y);
    endfunction

    function automatic logic signed [31:0] rnd_sat30(input logic signed [65:0] x);
        logic signed [65:0] y;
        y = (x + 66'sd536870912) >>> 30;
        return sat32(y);
    endfunction

endpackage

### hw/rtl/kts_ram.sv
`timescale 1ns / 1ps

module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/kts_div.sv
`timescale 1ns / 1ps

module kts_div
    import kts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W+1:0] sub;
    logic             ge;

    // one quotient bit a cycle, restoring
    assign trial = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign sub   = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge    = !sub[DVS_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DVD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? sub[DVS_W:0] : trial;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DVS_W-1:0];

endmodule

### hw/rtl/keyframe_track_sampler.sv
`timescale 1ns / 1ps
// Sample sequence: a time wrap and a time normalize, both on the shared 49-step serial
// divider and each skipped when the period or the gap is zero, with a key search from the
// hint between them; cubic mode adds the square, cube and Hermite basis states, then each
// component runs its mode's step sequence and waits for the output register to be free.
// Flow: one item at a time; loads and ignored kinds are taken without leaving idle.
// Reset: registers return to 2, 3, linear, 1.0 s; hint and previous time clear;
// the key tables are not cleared and hold nothing defined until loaded.
module keyframe_track_sampler
    import kts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // item input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [7:0]          s_key_index,
    input  logic [1:0]          s_slot,
    input  logic [2:0]          s_element,
    input  logic signed [31:0]  s_data_value,
    input  logic [31:0]         s_time_value,
    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_component,
    output logic signed [31:0]  m_sampled,
    output logic                m_last
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [8:0]  key_count_reg;
    logic [3:0]  comp_count_reg;
    logic [1:0]  mode_reg;
    logic [31:0] loop_period_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg   <= 9'd2;
            comp_count_reg  <= 4'd3;
            mode_reg        <= MODE_LINEAR;
            loop_period_reg <= 32'h0001_0000;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_KEY_COUNT:   key_count_reg   <= pwdata[8:0];
                REG_COMP_COUNT:  comp_count_reg  <= pwdata[3:0];
                REG_MODE:        mode_reg        <= pwdata[1:0];
                REG_LOOP_PERIOD: loop_period_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_KEY_COUNT:   prdata = {23'b0, key_count_reg};
            REG_COMP_COUNT:  prdata = {28'b0, comp_count_reg};
            REG_MODE:        prdata = {30'b0, mode_reg};
            REG_LOOP_PERIOD: prdata = loop_period_reg;
            default:         prdata = '0;
        endcase
    end

    // Saturate counts into their used ranges; mode 3 acts as linear.
    logic [8:0] n_eff;
    logic [3:0] nc_eff;
    logic [1:0] mode_eff;
    logic       cubic;

    assign n_eff  = (key_count_reg < 9'd2) ? 9'd2 :
                    (key_count_reg > 9'(MAX_KEYS)) ? 9'(MAX_KEYS) : key_count_reg;
    assign nc_eff = (comp_count_reg == 4'd0) ? 4'd1 :
                    (comp_count_reg > 4'(MAX_COMPONENTS)) ? 4'(MAX_COMPONENTS) : comp_count_reg;
    assign mode_eff = (mode_reg == MODE_STEP || mode_reg == MODE_CUBIC) ? mode_reg : MODE_LINEAR;
    assign cubic    = (mode_eff == MODE_CUBIC);

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    kts_state_t state_reg, state_next;

    logic        s_beat;
    logic        m_load;
    logic        out_free;

    logic [31:0] t_reg;
    logic [31:0] first_reg;
    logic [8:0]  idx_reg;
    logic [7:0]  next_reg;
    logic [7:0]  prev_reg;
    logic [7:0]  hint_reg;
    logic [31:0] ptime_reg;
    logic [31:0] ktn_reg;
    logic signed [32:0] gap_reg;
    logic signed [32:0] diff_reg;
    logic [16:0] tn_reg;
    logic [32:0] tn2_reg;
    logic [48:0] tn3_reg;
    logic signed [31:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic [3:0]  step_reg;
    logic [2:0]  comp_reg;
    logic signed [65:0] mul_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] b_reg, a_reg, res_reg;

    logic        m_valid_reg;
    logic [2:0]  m_component_reg;
    logic signed [31:0] m_sampled_reg;
    logic        m_last_reg;

    // memories
    logic [31:0]        kt_rdata;
    logic [KEY_W-1:0]   kt_raddr;
    logic [31:0]        kv_rdata;
    logic [VAL_AW-1:0]  kv_raddr;
    logic               kt_we, kv_we;

    // divider
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    // multiplier operands
    logic signed [32:0] mul_a, mul_b;

    logic [3:0]  last_step;
    logic        last_comp;
    logic [31:0] t_clamp;
    logic        srch_hit;
    logic [31:0] abs_diff, abs_gap;
    logic        tn_neg;
    logic [16:0] tn_calc;
    logic signed [51:0] t1_w, t2_w, t3_w;
    logic signed [51:0] x00, x10, x01, x11;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_beat   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_load   = (state_reg == ST_EMIT) && out_free;

    assign last_step = cubic ? LAST_STEP_CUBIC :
                       (mode_eff == MODE_STEP) ? LAST_STEP_STEP : LAST_STEP_LINEAR;
    assign last_comp = ({1'b0, comp_reg} == nc_eff - 4'd1);

    assign t_clamp  = (t_reg < first_reg) ? first_reg :
                      (t_reg > kt_rdata) ? kt_rdata : t_reg;
    assign srch_hit = (t_reg <= kt_rdata);

    assign abs_diff = diff_reg[32] ? 32'(-diff_reg) : diff_reg[31:0];
    assign abs_gap  = gap_reg[32] ? 32'(-gap_reg) : gap_reg[31:0];
    // negative quotient clamps to zero, one above 1.0 clamps to 1.0
    assign tn_neg   = (diff_reg[32] != gap_reg[32]) && (diff_reg != '0);
    assign tn_calc  = tn_neg ? 17'd0 :
                      (div_quo > DVD_W'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];

    // Hermite basis in Q48, rounded to Q30
    assign t1_w = $signed({3'b0, tn_reg, 32'b0});
    assign t2_w = $signed({3'b0, tn2_reg, 16'b0});
    assign t3_w = $signed({3'b0, tn3_reg});
    assign x00  = 52'sd2 * t3_w - 52'sd3 * t2_w + (52'sd1 <<< 48);
    assign x10  = t3_w - 52'sd2 * t2_w + t1_w;
    assign x01  = 52'sd3 * t2_w - 52'sd2 * t3_w;
    assign x11  = t3_w - t2_w;

    // ---------------------------------------------------------------------
    // FSM
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_dvd    = {17'b0, t_reg};
        div_dvs    = {1'b0, loop_period_reg};
        kt_raddr   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat && s_kind == KIND_SAMPLE) begin
                    state_next = ST_WRAP_GO;
                end
            end
            ST_WRAP_GO: begin
                // zero period: no wrap
                if (loop_period_reg == '0) begin
                    state_next = ST_RD_FIRST;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WRAP_WAIT;
                end
            end
            ST_WRAP_WAIT: begin
                if (div_done) begin
                    state_next = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST: begin
                kt_raddr   = '0;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST: begin
                kt_raddr   = KEY_W'(n_eff - 9'd1);
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                state_next = ST_SRCH_ADDR;
            end
            ST_SRCH_ADDR: begin
                kt_raddr   = idx_reg[KEY_W-1:0];
                state_next = (idx_reg >= n_eff) ? ST_RD_NEXT : ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                state_next = srch_hit ? ST_RD_NEXT : ST_SRCH_ADDR;
            end
            ST_RD_NEXT: begin
                kt_raddr   = next_reg;
                state_next = ST_RD_PREV;
            end
            ST_RD_PREV: begin
                kt_raddr   = prev_reg;
                state_next = ST_GAP;
            end
            ST_GAP: begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_dvd = {1'b0, abs_diff, 16'b0};
                div_dvs = {1'b0, abs_gap};
                if (gap_reg == '0) begin
                    state_next = cubic ? ST_SQ : ST_COMP;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = cubic ? ST_SQ : ST_COMP;
                end
            end
            ST_SQ:   state_next = ST_CUBE;
            ST_CUBE: state_next = ST_HERM;
            ST_HERM: state_next = ST_COMP;
            ST_COMP: begin
                if (step_reg == last_step) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = last_comp ? ST_IDLE : ST_COMP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Search hint and previous time carry across samples.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg  <= '0;
            ptime_reg <= '0;
        end else if (state_reg == ST_CLAMP) begin
            ptime_reg <= t_clamp;
        end else if (state_reg == ST_SRCH_ADDR && idx_reg >= n_eff) begin
            hint_reg <= '0;
        end else if (state_reg == ST_SRCH_CMP && srch_hit) begin
            hint_reg <= (idx_reg == '0) ? 8'd0 : 8'(idx_reg - 9'd1);
        end
    end

    // Sample datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                t_reg    <= s_time_value;
                step_reg <= '0;
                comp_reg <= '0;
                tn_reg   <= '0;
            end
            ST_WRAP_WAIT: begin
                if (div_done) begin
                    t_reg <= div_rem[31:0];
                end
            end
            ST_RD_LAST: first_reg <= kt_rdata;
            ST_CLAMP: begin
                t_reg <= t_clamp;
                // time went backward: restart the search from key 0
                idx_reg <= (ptime_reg > t_clamp) ? 9'd0 : {1'b0, hint_reg};
            end
            ST_SRCH_ADDR: begin
                if (idx_reg >= n_eff) begin
                    next_reg <= '0;
                    prev_reg <= '0;
                end
            end
            ST_SRCH_CMP: begin
                if (srch_hit) begin
                    next_reg <= (idx_reg == '0) ? 8'd1 : idx_reg[7:0];
                    prev_reg <= (idx_reg == '0) ? 8'd0 : 8'(idx_reg - 9'd1);
                end else begin
                    idx_reg <= idx_reg + 9'd1;
                end
            end
            ST_RD_PREV: ktn_reg <= kt_rdata;
            ST_GAP: begin
                gap_reg  <= $signed({1'b0, ktn_reg}) - $signed({1'b0, kt_rdata});
                diff_reg <= $signed({1'b0, t_reg}) - $signed({1'b0, kt_rdata});
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    tn_reg <= tn_calc;
                end
            end
            ST_SQ:   tn2_reg <= 33'(tn_reg * tn_reg);
            ST_CUBE: tn3_reg <= 49'(tn2_reg * tn_reg);
            ST_HERM: begin
                h00_reg <= 32'((x00 + 52'sd131072) >>> 18);
                h10_reg <= 32'((x10 + 52'sd131072) >>> 18);
                h01_reg <= 32'((x01 + 52'sd131072) >>> 18);
                h11_reg <= 32'((x11 + 52'sd131072) >>> 18);
            end
            ST_COMP: begin
                step_reg <= step_reg + 4'd1;
                if (cubic) begin
                    case (step_reg)
                        4'd2: b_reg   <= rnd_sat16(mul_reg);
                        4'd3: a_reg   <= rnd_sat16(mul_reg);
                        4'd4: acc_reg <= mul_reg;
                        4'd5, 4'd6, 4'd7: acc_reg <= acc_reg + mul_reg;
                        4'd8: res_reg <= rnd_sat30(acc_reg);
                        default: ;
                    endcase
                end else if (mode_eff == MODE_STEP) begin
                    if (step_reg == LAST_STEP_STEP) begin
                        res_reg <= kv_rdata;
                    end
                end else begin
                    case (step_reg)
                        4'd2: acc_reg <= mul_reg;
                        4'd3: acc_reg <= acc_reg + mul_reg;
                        4'd4: res_reg <= rnd_sat16(acc_reg);
                        default: ;
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    step_reg <= '0;
                    comp_reg <= comp_reg + 3'd1;
                end
            end
            default: ;
        endcase
        mul_reg <= mul_a * mul_b;
    end

    // Per-component read and multiply schedule; read data lands in the next step.
    always_comb begin
        kv_raddr = val_addr(prev_reg, SLOT_VAL, comp_reg);
        mul_a    = '0;
        mul_b    = '0;
        if (state_reg == ST_COMP) begin
            if (cubic) begin
                case (step_reg)
                    4'd0: kv_raddr = val_addr(prev_reg, SLOT_OUT, comp_reg);
                    4'd1: begin
                        kv_raddr = val_addr(next_reg, SLOT_IN, comp_reg);
                        mul_a    = gap_reg;
                        mul_b    = $signed({kv_rdata[31], kv_rdata});
                    end
                    4'd2: begin
                        kv_raddr = val_addr(prev_reg, SLOT_VAL, comp_reg);
                        mul_a    = gap_reg;
                        mul_b    = $signed({kv_rdata[31], kv_rdata});
                    end
                    4'd3: begin
                        kv_raddr = val_addr(next_reg, SLOT_VAL, comp_reg);
                        mul_a    = $signed({kv_rdata[31], kv_rdata});
                        mul_b    = $signed({h00_reg[31], h00_reg});
                    end
                    4'd4: begin
                        mul_a = $signed({kv_rdata[31], kv_rdata});
                        mul_b = $signed({h01_reg[31], h01_reg});
                    end
                    4'd5: begin
                        mul_a = $signed({b_reg[31], b_reg});
                        mul_b = $signed({h10_reg[31], h10_reg});
                    end
                    4'd6: begin
                        mul_a = $signed({a_reg[31], a_reg});
                        mul_b = $signed({h11_reg[31], h11_reg});
                    end
                    default: ;
                endcase
            end else if (mode_eff != MODE_STEP) begin
                case (step_reg)
                    4'd1: begin
                        kv_raddr = val_addr(next_reg, SLOT_VAL, comp_reg);
                        mul_a    = $signed({kv_rdata[31], kv_rdata});
                        mul_b    = $signed({16'b0, 17'(ONE_Q16 - tn_reg)});
                    end
                    4'd2: begin
                        mul_a = $signed({kv_rdata[31], kv_rdata});
                        mul_b = $signed({16'b0, tn_reg});
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: holds a beat while the next component is computed
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_component_reg <= comp_reg;
            m_sampled_reg   <= res_reg;
            m_last_reg      <= last_comp;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_component = m_component_reg;
    assign m_sampled   = m_sampled_reg;
    assign m_last      = m_last_reg;

    // ---------------------------------------------------------------------
    // Tables and divider
    // ---------------------------------------------------------------------
    assign kt_we = s_beat && (s_kind == KIND_TIME);
    assign kv_we = s_beat && (s_kind == KIND_VALUE) && (s_slot != SLOT_BAD);

    kts_ram #(
        .WIDTH(32),
        .DEPTH(MAX_KEYS)
    ) u_key_times (
        .aclk  (aclk),
        .we    (kt_we),
        .waddr (s_key_index),
        .wdata (s_time_value),
        .raddr (kt_raddr),
        .rdata (kt_rdata)
    );

    kts_ram #(
        .WIDTH(32),
        .DEPTH(VAL_DEPTH)
    ) u_key_values (
        .aclk  (aclk),
        .we    (kv_we),
        .waddr (val_addr(s_key_index, s_slot, s_element)),
        .wdata (s_data_value),
        .raddr (kv_raddr),
        .rdata (kv_rdata)
    );

    kts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WRAP_WAIT || state_reg == ST_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_sample_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_kind == KIND_SAMPLE |=> !s_ready)
        else $error("input taken again right after a sample beat");

    a_tn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMP |-> tn_reg <= ONE_Q16)
        else $error("normalized time above 1.0");

endmodule

### verif/tb_keyframe_track_sampler.sv
`timescale 1ns / 1ps

module tb_keyframe_track_sampler;
    import kts_pkg::*;

    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  N_RANDOM     = 160;
    // keys that carry values; key MAX_KEYS-1 only carries a time that caps the track
    localparam int  KEYS_LOADED  = 12;

    // one expected result beat
    typedef struct {
        logic [2:0]         component;
        logic signed [31:0] sampled;
        logic               last;
    } track_beat_t;

    // Predictor of the sampler plus the store of results still to come.
    class track_scoreboard;
        logic [31:0]        key_time [MAX_KEYS];
        logic signed [31:0] key_value [VAL_DEPTH];
        logic [7:0]         hint;
        logic [31:0]        prev_time;
        logic [8:0]         key_count;
        logic [3:0]         comp_count;
        logic [1:0]         mode;
        logic [31:0]        loop_period;
        track_beat_t        expected_beats [$];
        int                 errors;
        int                 beats_checked;
        int                 samples;

        function new();
            hint = 0;
            prev_time = 0;
            key_count = 2;
            comp_count = 3;
            mode = MODE_LINEAR;
            loop_period = 32'd65536;
            errors = 0;
            beats_checked = 0;
            samples = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_KEY_COUNT:   key_count = v[8:0];
                REG_COMP_COUNT:  comp_count = v[3:0];
                REG_MODE:        mode = v[1:0];
                REG_LOOP_PERIOD: loop_period = v;
                default: ;
            endcase
        endfunction

        function longint rshift(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint sat(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint val(int k, logic [1:0] s, int el);
            return longint'(key_value[(k * 3 + s) * MAX_COMPONENTS + el]);
        endfunction

        // note an accepted input beat; samples push their expected results
        function void note_item(logic [1:0] kind, logic [7:0] idx, logic [1:0] slot,
                                logic [2:0] el, logic signed [31:0] data,
                                logic [31:0] tq);
            int      n;
            int      nc;
            int      nxt;
            int      prv;
            logic [31:0] t;
            longint  gap;
            longint  diff;
            longint  tn;
            longint  h00;
            longint  h10;
            longint  h01;
            longint  h11;
            longint  r;
            longint  t1;
            longint  t2;
            longint  t3;
            longint  a;
            longint  b;
            track_beat_t beat;

            if (kind == KIND_TIME) begin
                key_time[idx] = tq;
                return;
            end
            if (kind == KIND_VALUE) begin
                if (slot != SLOT_BAD) key_value[(idx * 3 + slot) * MAX_COMPONENTS + el] = data;
                return;
            end
            if (kind != KIND_SAMPLE) return;

            samples++;
            n = (key_count < 2) ? 2 : ((key_count > MAX_KEYS) ? MAX_KEYS : key_count);
            nc = (comp_count < 1) ? 1 : ((comp_count > MAX_COMPONENTS) ? MAX_COMPONENTS
                                                                       : comp_count);
            t = tq;
            if (loop_period != 0) t = t % loop_period;
            if (t < key_time[0]) t = key_time[0];
            else if (t > key_time[n - 1]) t = key_time[n - 1];

            // backward time restarts the search from the first key
            if (prev_time > t) hint = 0;
            prev_time = t;
            nxt = 0;
            for (int i = hint; i < n; i++) begin
                if (t <= key_time[i]) begin
                    nxt = (i < 1) ? 1 : i;
                    break;
                end
            end
            prv = (nxt > 0) ? nxt - 1 : 0;
            hint = prv[7:0];

            gap = longint'({32'd0, key_time[nxt]}) - longint'({32'd0, key_time[prv]});
            diff = longint'({32'd0, t}) - longint'({32'd0, key_time[prv]});
            if (gap == 0) begin
                tn = 0;
            end else begin
                tn = (diff * 65536) / gap;
                if (tn < 0) tn = 0;
                if (tn > 65536) tn = 65536;
            end

            h00 = 0; h10 = 0; h01 = 0; h11 = 0;
            if (mode == MODE_CUBIC) begin
                t1 = tn * (64'sd1 <<< 32);
                t2 = tn * tn * 65536;
                t3 = tn * tn * tn;
                h00 = rshift(2 * t3 - 3 * t2 + (64'sd1 <<< 48), 18);
                h10 = rshift(t3 - 2 * t2 + t1, 18);
                h01 = rshift(-2 * t3 + 3 * t2, 18);
                h11 = rshift(t3 - t2, 18);
            end

            for (int c = 0; c < nc; c++) begin
                if (mode == MODE_STEP) begin
                    r = val(prv, SLOT_VAL, c);
                end else if (mode == MODE_CUBIC) begin
                    b = sat(rshift(gap * val(prv, SLOT_OUT, c), 16));
                    a = sat(rshift(gap * val(nxt, SLOT_IN, c), 16));
                    r = sat(rshift(val(prv, SLOT_VAL, c) * h00 + b * h10
                                   + val(nxt, SLOT_VAL, c) * h01 + a * h11, 30));
                end else begin
                    r = sat(rshift(val(prv, SLOT_VAL, c) * (65536 - tn)
                                   + val(nxt, SLOT_VAL, c) * tn, 16));
                end
                beat.component = c[2:0];
                beat.sampled = r[31:0];
                beat.last = (c == nc - 1);
                expected_beats.push_back(beat);
            end
        endfunction

        // compare one result beat against the oldest expectation
        function void check_beat(logic [2:0] comp, logic signed [31:0] smp, logic lst);
            track_beat_t e;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat comp=%0d sampled=%0d last=%0b",
                         $time, comp, smp, lst);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            if (comp !== e.component) begin
                $display("%0t: component expected %0d actual %0d", $time, e.component, comp);
                errors++;
            end
            if (smp !== e.sampled) begin
                $display("%0t: sampled expected %0d actual %0d (comp %0d)",
                         $time, e.sampled, smp, e.component);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [7:0]         s_key_index;
    logic [1:0]         s_slot;
    logic [2:0]         s_element;
    logic signed [31:0] s_data_value;
    logic [31:0]        s_time_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_component;
    logic signed [31:0] m_sampled;
    logic               m_last;

    track_scoreboard sb;
    bit              quiet;     // no idling on either side
    bit              scrambled; // key times out of order: keep the track short
    int              cycles;
    int              cfg_writes;
    logic [31:0]     cursor;    // running query time for well-formed sweeps

    keyframe_track_sampler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_key_index(s_key_index), .s_slot(s_slot), .s_element(s_element),
        .s_data_value(s_data_value), .s_time_value(s_time_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_component(m_component),
        .m_sampled(m_sampled), .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: fail the run if it hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("keyframe_track_sampler verification failed");
            $finish;
        end
    end

    // check every result beat taken by the receiver
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_beat(m_component, m_sampled, m_last);
    end

    // receiver: hold ready high, drop it in random bursts unless quiet
    initial begin
        m_ready = 1'b1;
        forever begin
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // send one beat; valid stays high into the next call unless a gap is drawn
    task automatic send_beat(logic [1:0] kind, logic [7:0] idx, logic [1:0] slot,
                             logic [2:0] el, logic [31:0] data, logic [31:0] tq);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_key_index  <= idx;
        s_slot       <= slot;
        s_element    <= el;
        s_data_value <= data;
        s_time_value <= tq;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(kind, idx, slot, el, data, tq);
    endtask

    task automatic sample_at(logic [31:0] tq);
        send_beat(KIND_SAMPLE, 8'($urandom), 2'($urandom), 3'($urandom), $urandom, tq);
    endtask

    // drop valid and wait for every expected result plus the block to settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup then access, register taken when pready is seen high
    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, v);
        cfg_writes++;
    endtask

    task automatic set_track(logic [8:0] kc, logic [3:0] ncomp, logic [1:0] md,
                             logic [31:0] lp);
        drain();
        reg_write(REG_KEY_COUNT, {23'd0, kc});
        reg_write(REG_COMP_COUNT, {28'd0, ncomp});
        reg_write(REG_MODE, {30'd0, md});
        reg_write(REG_LOOP_PERIOD, lp);
    endtask

    // reload key times: ascending, with repeats, or scrambled; the top key repeats
    // the last loaded time so a full-length track never searches past loaded keys
    task automatic load_times(int shape);
        logic [31:0] t;
        t = $urandom_range(0, 65535);
        for (int i = 0; i < KEYS_LOADED; i++) begin
            case (shape)
                0: t = t + $urandom_range(1, 200000);
                1: t = t + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90000));
                default: t = $urandom;
            endcase
            send_beat(KIND_TIME, i[7:0], 2'($urandom), 3'($urandom), $urandom, t);
        end
        send_beat(KIND_TIME, 8'(MAX_KEYS - 1), 2'($urandom), 3'($urandom), $urandom, t);
        scrambled = (shape > 1);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // pick a query time: mostly a forward sweep, some jumps back and noise
    function automatic logic [31:0] next_query(int n);
        logic [31:0] lo;
        logic [31:0] hi;
        int          m;
        lo = sb.key_time[0];
        hi = sb.key_time[n - 1];
        m  = (n > KEYS_LOADED) ? KEYS_LOADED : n;
        case ($urandom_range(0, 9))
            0: cursor = $urandom;
            1: cursor = lo + ((hi > lo) ? $urandom_range(0, hi - lo) : 0);
            2: cursor = sb.key_time[$urandom_range(0, m - 1)];
            default: cursor = cursor + $urandom_range(0, 300000);
        endcase
        return cursor;
    endfunction

    logic [8:0]  kc;
    logic [3:0]  ncomp;
    logic [31:0] lp;
    logic [31:0] span;
    int          n_eff;

    initial begin
        sb = new();
        quiet = 1'b0;
        scrambled = 1'b0;
        cycles = 0;
        cfg_writes = 0;
        cursor = 0;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_kind = '0; s_key_index = '0; s_slot = '0; s_element = '0;
        s_data_value = '0; s_time_value = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every entry a sample can reach before the first sample
        load_times(0);
        for (int k = 0; k < KEYS_LOADED; k++)
            for (int s = 0; s < 3; s++)
                for (int e = 0; e < MAX_COMPONENTS; e++)
                    send_beat(KIND_VALUE, k[7:0], s[1:0], e[2:0], rand_value(), $urandom);

        // directed: reset settings, then each mode at the field extremes
        sample_at(32'd0);
        sample_at(32'd32768);
        set_track(9'd4, 4'd3, MODE_LINEAR, 32'd0);
        sample_at(32'd0);                              // clamp to first key
        sample_at(sb.key_time[1]);                     // exactly on a key
        sample_at(sb.key_time[1] + 32'd7);
        sample_at(32'hffffffff);                       // clamp to last key
        sample_at(sb.key_time[0] + 32'd3);             // time goes backward
        send_beat(KIND_VALUE, 8'd1, SLOT_BAD, 3'd7, 32'h7fffffff, 32'd0);  // bad slot
        send_beat(2'd3, 8'hff, SLOT_VAL, 3'd0, 32'h12345678, 32'hffffffff); // ignored kind
        sample_at(sb.key_time[2]);
        set_track(9'd256, 4'd8, MODE_STEP, 32'hffffffff);
        sample_at(sb.key_time[KEYS_LOADED - 2] + 32'd1);
        sample_at(sb.key_time[MAX_KEYS - 1]);
        set_track(9'd2, 4'd1, MODE_CUBIC, 32'd1);      // period one wraps every time to 0
        sample_at($urandom);
        set_track(9'd0, 4'd0, MODE_CUBIC, sb.key_time[1] + 32'd5);
        sample_at(sb.key_time[0] + 32'd100);
        sample_at(sb.key_time[1] + 32'd3);             // below the period: no wrap, clamps to the last key
        set_track(9'd511, 4'd15, 2'd3, 32'd0);         // saturated counts, mode 3 as linear
        sample_at(sb.key_time[7]);
        sample_at(sb.key_time[7] + 32'd9);
        load_times(1);                                 // repeated key times: zero gaps
        set_track(9'd8, 4'd2, MODE_CUBIC, 32'd0);
        sample_at(sb.key_time[3]);
        sample_at(sb.key_time[5] + 32'd1);

        // random phases: new settings, some table churn, then samples
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 7) quiet = 1'b1;                 // last part runs without idling
            if (ph == 4) load_times(2);                // scrambled key times
            else if (ph == 6) load_times(0);
            if (!scrambled && $urandom_range(0, 3) == 0)
                kc = 9'($urandom_range(256, 511));
            else
                kc = 9'($urandom_range(0, KEYS_LOADED));
            if (ph == 9) kc = 9'd256;
            ncomp = 4'($urandom_range(0, 15));
            n_eff = (kc < 2) ? 2 : ((kc > MAX_KEYS) ? MAX_KEYS : kc);
            span = sb.key_time[n_eff - 1];
            case ($urandom_range(0, 3))
                0: lp = 32'd0;
                1: lp = $urandom;
                default: lp = span + $urandom_range(1, 500000);
            endcase
            set_track(kc, ncomp, 2'($urandom), lp);
            cursor = sb.key_time[0];
            for (int i = 0; i < N_RANDOM / 10; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_beat(($urandom_range(0, 5) == 0) ? 2'd3 : KIND_VALUE,
                              8'($urandom_range(0, KEYS_LOADED - 1)), 2'($urandom),
                              3'($urandom), rand_value(), $urandom);
                else
                    sample_at(next_query(n_eff));
            end
        end

        drain();
        $display("covered %0d samples and %0d result beats over %0d register writes",
                 sb.samples, sb.beats_checked, cfg_writes);
        $display("modes linear, step, cubic and 3; wrap, clamp, zero gaps, backward time");
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("keyframe_track_sampler verification clean");
        end else begin
            $display("keyframe_track_sampler verification failed");
        end
        $finish;
    end

endmodule
